// ----- hw/rtl/ca_pkg.sv -----
// shared types, constants and helpers for the cellular automaton generation step
// no dependencies; imported by every ca_* module and the top level
package ca_pkg;

  localparam int unsigned CFG_W        = 11;
  localparam int unsigned CFG_IDX_W    = 1;
  localparam int unsigned MAX_COLS_DEF = 1024;
  localparam int unsigned MAX_ROWS_DEF = 1024;
  localparam int unsigned WIN_COLS     = 2;

  localparam logic [CFG_W-1:0] CFG_RESET = 11'd64;
  localparam logic [CFG_W-1:0] DIM_MIN   = 11'd3;

  // live neighbour counts that give a live cell in the next generation
  localparam logic [3:0] LIVE_LO = 4'd2;
  localparam logic [3:0] LIVE_HI = 4'd3;

  // input row position saturates here, only rows 0, 1 and beyond matter
  localparam logic [1:0] ROW_ONE = 2'd1;
  localparam logic [1:0] ROW_SAT = 2'd2;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GRID_ROWS = 1'b0,
    REG_GRID_COLS = 1'b1
  } cfg_reg_e;

  // one line buffer entry: cells two rows and one row above
  typedef struct packed {
    logic upper;
    logic middle;
  } line_t;

  // one window column, newest row in the top bit
  typedef struct packed {
    logic fresh;
    logic middle;
    logic upper;
  } col_t;

  function automatic logic [1:0] col_count(col_t c);
    return 2'(c.upper) + 2'(c.middle) + 2'(c.fresh);
  endfunction

endpackage

// ----- hw/rtl/ca_line_buf.sv -----
// two-row line buffer, one entry per column, registered read with write-first bypass
// depends on ca_pkg
module ca_line_buf #(
  parameter int unsigned DEPTH = ca_pkg::MAX_COLS_DEF,
  localparam int unsigned AW = $clog2(DEPTH)
) (
  input  logic          clk_i,
  input  logic          rd_en_i,
  input  logic [AW-1:0] rd_addr_i,
  output ca_pkg::line_t rd_data_o,
  input  logic          wr_en_i,
  input  logic [AW-1:0] wr_addr_i,
  input  ca_pkg::line_t wr_data_i
);
  import ca_pkg::*;

  line_t mem_q [DEPTH];
  line_t rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      if (wr_en_i && (wr_addr_i == rd_addr_i)) begin
        rd_data_q <= wr_data_i;
      end else begin
        rd_data_q <= mem_q[rd_addr_i];
      end
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// ----- hw/rtl/ca_win_cell.sv -----
// one column cell of the 3x3 window chain, holds a column and its live count
// depends on ca_pkg
module ca_win_cell (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         en_i,
  input  ca_pkg::col_t col_i,
  output ca_pkg::col_t col_o,
  output logic [1:0]   cnt_o
);
  import ca_pkg::*;

  col_t       col_q;
  logic [1:0] cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      cnt_q <= '0;
    end else if (en_i) begin
      col_q <= col_i;
      cnt_q <= col_count(col_i);
    end
  end

  assign col_o = col_q;
  assign cnt_o = cnt_q;

endmodule

// ----- hw/rtl/ca_div.sv -----
// restoring divider, one quotient bit per cycle, splits the output count into row and column
// depends on ca_pkg
module ca_div #(
  parameter int unsigned DVD_W = 20,
  parameter int unsigned DSR_W = ca_pkg::CFG_W
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [DVD_W-1:0] dividend_i,
  input  logic [DSR_W-1:0] divisor_i,
  output logic             busy_o,
  output logic             done_o,
  output logic [DVD_W-1:0] quot_o,
  output logic [DSR_W-1:0] rem_o
);
  import ca_pkg::*;

  localparam int unsigned CW = $clog2(DVD_W + 1);

  logic [DSR_W-1:0] rem_q;
  logic [DVD_W-1:0] quo_q;
  logic [CW-1:0]    cnt_q;
  logic             done_q;
  logic [DSR_W:0]   shifted;
  logic             ge;
  logic [DSR_W-1:0] rem_d;

  always_comb begin
    shifted = {rem_q, quo_q[DVD_W-1]};
    ge      = shifted >= {1'b0, divisor_i};
    if (ge) begin
      rem_d = DSR_W'(shifted - {1'b0, divisor_i});
    end else begin
      rem_d = DSR_W'(shifted);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= (cnt_q == CW'(1)) && !start_i;
      if (start_i) begin
        cnt_q <= CW'(DVD_W);
      end else if (cnt_q != '0) begin
        cnt_q <= cnt_q - CW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= dividend_i;
    end else if (cnt_q != '0) begin
      rem_q <= rem_d;
      quo_q <= {quo_q[DVD_W-2:0], ge};
    end
  end

  assign busy_o = (cnt_q != '0) || done_q;
  assign done_o = done_q;
  assign quot_o = quo_q;
  assign rem_o  = rem_q;

  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |=> busy_o)
    else $error("divider not busy after start");

  a_count_down: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q != '0) && !start_i |=> cnt_q == $past(cnt_q) - CW'(1))
    else $error("divider step count skipped");

  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> cnt_q == '0)
    else $error("divider done while still stepping");

endmodule

// ----- hw/rtl/cellular_automaton_generation_step.sv -----
// One generation of a two-state life-like automaton (birth and survival on 2 or 3 live
// neighbours) over a grid streamed in raster order, one cell per word. Sustained rate is
// one word per cycle while the output accepts, set by one read and one write of the column
// line buffer per word; a word passes one register stage, s1, before its completed result
// is registered in the output register. Results lag the input by grid_cols+1 words, so
// grid_cols+1 flush words drain a grid. After reset all MAX_COLS line buffer entries are
// cleared, and after every register write the divider re-derives the output position; no
// word is accepted during either. Border cells pass through unchanged.
// depends on ca_pkg, ca_line_buf, ca_win_cell, ca_div
module cellular_automaton_generation_step #(
  parameter int unsigned MAX_COLS = ca_pkg::MAX_COLS_DEF,
  parameter int unsigned MAX_ROWS = ca_pkg::MAX_ROWS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [ca_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [ca_pkg::CFG_W-1:0]     cfg_data_i,
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  input  logic [7:0]                   s_axis_tdata,   // [0] cell_in
  input  logic [0:0]                   s_axis_tuser,   // [0] flush
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  output logic [7:0]                   m_axis_tdata,   // [0] cell_out
  output logic                         m_axis_tlast
);
  import ca_pkg::*;

  localparam int unsigned COL_W = $clog2(MAX_COLS);
  localparam int unsigned CNT_W = $clog2(MAX_ROWS * MAX_COLS);
  localparam int unsigned TOT_W = CNT_W + 1;
  localparam int unsigned PRD_W = 2 * CFG_W;

  typedef struct packed {
    logic             emit;
    logic             inner;
    logic             last;
    logic             bit_in;
    logic [COL_W-1:0] col;
  } s1_t;

  // configuration
  logic [CFG_W-1:0] grid_rows_q, grid_cols_q;
  logic [CFG_W-1:0] rows_c, cols_c;
  logic [TOT_W-1:0] total_q;
  logic             start_q;

  // input position and output position
  logic [COL_W-1:0] in_col_q, in_col_d;
  logic [1:0]       in_row_q, in_row_d;
  logic [CNT_W-1:0] out_count_q;
  logic [CNT_W-1:0] out_row_q;
  logic [CFG_W-1:0] out_col_q;

  // line buffer clearing
  logic             clr_busy_q;
  logic [COL_W-1:0] clr_addr_q;

  // pipeline
  logic             en, acc, busy, wr_s1;
  logic             cell0, col_wrap, step_wrap, emit0, last0, inner0;
  logic [COL_W-1:0] c0;
  logic [1:0]       r0;
  logic [31:0]      c_inc;
  logic             v1_q;
  s1_t              s1_q;
  line_t            rd_data, wr_data;
  logic [COL_W-1:0] wr_addr;
  logic             wr_en;

  // window and rule
  col_t             new_col;
  col_t             win_col [WIN_COLS];
  logic [1:0]       win_cnt [WIN_COLS];
  logic [3:0]       nbr;
  logic             centre, nxt_cell;

  // output register
  logic             m_valid_q, m_data_q, m_last_q;

  // divider
  logic             div_busy, div_done;
  logic [CNT_W-1:0] div_quot;
  logic [CFG_W-1:0] div_rem;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    if (grid_rows_q < DIM_MIN) begin
      rows_c = DIM_MIN;
    end else if (32'(grid_rows_q) > MAX_ROWS) begin
      rows_c = CFG_W'(MAX_ROWS);
    end else begin
      rows_c = grid_rows_q;
    end
    if (grid_cols_q < DIM_MIN) begin
      cols_c = DIM_MIN;
    end else if (32'(grid_cols_q) > MAX_COLS) begin
      cols_c = CFG_W'(MAX_COLS);
    end else begin
      cols_c = grid_cols_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grid_rows_q <= CFG_RESET;
      grid_cols_q <= CFG_RESET;
      start_q     <= 1'b0;
      total_q     <= TOT_W'(PRD_W'(CFG_RESET) * PRD_W'(CFG_RESET));
    end else begin
      start_q <= cfg_valid_i;
      total_q <= TOT_W'(PRD_W'(rows_c) * PRD_W'(cols_c));
      if (cfg_valid_i) begin
        case (cfg_reg_e'(cfg_index_i))
          REG_GRID_ROWS: grid_rows_q <= cfg_data_i;
          REG_GRID_COLS: grid_cols_q <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  ca_div #(
    .DVD_W(CNT_W),
    .DSR_W(CFG_W)
  ) u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (start_q),
    .dividend_i(out_count_q),
    .divisor_i (cols_c),
    .busy_o    (div_busy),
    .done_o    (div_done),
    .quot_o    (div_quot),
    .rem_o     (div_rem)
  );

  assign busy          = clr_busy_q || start_q || div_busy;
  assign en            = !m_valid_q || m_axis_tready;
  assign s_axis_tready = en && !busy;
  assign acc           = s_axis_tvalid && s_axis_tready;
  assign wr_s1         = en && v1_q;

  // input side: position, emit decision and output position
  always_comb begin
    cell0    = s_axis_tuser[0] ? 1'b0 : s_axis_tdata[0];
    col_wrap = 32'(in_col_q) >= 32'(cols_c);
    c0       = col_wrap ? '0 : in_col_q;
    if (col_wrap) begin
      r0 = (in_row_q == ROW_SAT) ? ROW_SAT : in_row_q + 2'd1;
    end else begin
      r0 = in_row_q;
    end
    emit0     = (r0 == ROW_SAT) || ((r0 == ROW_ONE) && (c0 != '0));
    c_inc     = 32'(c0) + 32'd1;
    step_wrap = c_inc >= 32'(cols_c);
    if (step_wrap) begin
      in_col_d = '0;
      in_row_d = (r0 == ROW_SAT) ? ROW_SAT : r0 + 2'd1;
    end else begin
      in_col_d = COL_W'(c_inc);
      in_row_d = r0;
    end
    last0  = (32'(out_count_q) + 32'd1) >= 32'(total_q);
    inner0 = (out_row_q != '0) && ((32'(out_row_q) + 32'd2) <= 32'(rows_c)) &&
             (out_col_q != '0) && ((32'(out_col_q) + 32'd2) <= 32'(cols_c));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_col_q    <= '0;
      in_row_q    <= '0;
      out_count_q <= '0;
      out_row_q   <= '0;
      out_col_q   <= '0;
    end else if (div_done) begin
      out_row_q <= div_quot;
      out_col_q <= div_rem;
    end else if (acc) begin
      if (emit0 && last0) begin
        in_col_q    <= '0;
        in_row_q    <= '0;
        out_count_q <= '0;
        out_row_q   <= '0;
        out_col_q   <= '0;
      end else begin
        in_col_q <= in_col_d;
        in_row_q <= in_row_d;
        if (emit0) begin
          out_count_q <= out_count_q + CNT_W'(1);
          if ((32'(out_col_q) + 32'd1) >= 32'(cols_c)) begin
            out_col_q <= '0;
            out_row_q <= out_row_q + CNT_W'(1);
          end else begin
            out_col_q <= out_col_q + CFG_W'(1);
          end
        end
      end
    end
  end

  // line buffer clearing after reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_busy_q <= 1'b1;
      clr_addr_q <= '0;
    end else if (clr_busy_q) begin
      clr_addr_q <= clr_addr_q + COL_W'(1);
      if (clr_addr_q == COL_W'(MAX_COLS - 1)) begin
        clr_busy_q <= 1'b0;
      end
    end
  end

  always_comb begin
    wr_en = clr_busy_q || wr_s1;
    if (clr_busy_q) begin
      wr_addr = clr_addr_q;
      wr_data = '0;
    end else begin
      wr_addr        = s1_q.col;
      wr_data.upper  = rd_data.middle;
      wr_data.middle = s1_q.bit_in;
    end
  end

  ca_line_buf #(
    .DEPTH(MAX_COLS)
  ) u_line_buf (
    .clk_i    (clk_i),
    .rd_en_i  (acc),
    .rd_addr_i(c0),
    .rd_data_o(rd_data),
    .wr_en_i  (wr_en),
    .wr_addr_i(wr_addr),
    .wr_data_i(wr_data)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (en) begin
      v1_q <= acc;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_q.emit   <= emit0;
      s1_q.inner  <= inner0;
      s1_q.last   <= last0;
      s1_q.bit_in <= cell0;
      s1_q.col    <= c0;
    end
  end

  // window chain: newest column enters cell 0, centre column sits in cell 0
  always_comb begin
    new_col.fresh  = s1_q.bit_in;
    new_col.middle = rd_data.middle;
    new_col.upper  = rd_data.upper;
  end

  for (genvar k = 0; k < WIN_COLS; k++) begin : g_win
    if (k == 0) begin : g_head
      ca_win_cell u_cell (
        .clk_i (clk_i),
        .rst_ni(rst_ni),
        .en_i  (wr_s1),
        .col_i (new_col),
        .col_o (win_col[k]),
        .cnt_o (win_cnt[k])
      );
    end else begin : g_body
      ca_win_cell u_cell (
        .clk_i (clk_i),
        .rst_ni(rst_ni),
        .en_i  (wr_s1),
        .col_i (win_col[k-1]),
        .col_o (win_col[k]),
        .cnt_o (win_cnt[k])
      );
    end
  end

  always_comb begin
    centre   = win_col[0].middle;
    nbr      = 4'(col_count(new_col)) + 4'(win_cnt[0]) + 4'(win_cnt[1]) - 4'(centre);
    nxt_cell = s1_q.inner ? ((nbr == LIVE_LO) || (nbr == LIVE_HI)) : centre;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (en) begin
      m_valid_q <= v1_q && s1_q.emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      m_data_q <= nxt_cell;
      m_last_q <= s1_q.last;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {7'd0, m_data_q};
  assign m_axis_tlast  = m_last_q;

  a_no_word_clearing: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clr_busy_q |-> !s_axis_tready)
    else $error("word accepted while line buffer clears");

  a_grid_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc && emit0 && last0 && !div_done |=>
      (in_col_q == '0) && (in_row_q == '0) && (out_count_q == '0))
    else $error("positions not cleared after last cell");

  a_out_col_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy |-> 32'(out_col_q) < 32'(cols_c))
    else $error("output column beyond grid width");

endmodule

// ----- tb/ca_generation_checker.sv -----
// checker for the cellular automaton generation step: snoops the register channel and
// both streams, predicts each result word from its own copy of the grid state and compares
// depends on ca_pkg; instantiated beside the block by the testbench top
`timescale 1ns / 100ps

module ca_generation_checker #(
  parameter int unsigned MAX_COLS = ca_pkg::MAX_COLS_DEF,
  parameter int unsigned MAX_ROWS = ca_pkg::MAX_ROWS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_valid_i,
  input  logic                         cfg_ready_i,
  input  logic [ca_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [ca_pkg::CFG_W-1:0]     cfg_data_i,
  input  logic                         in_valid_i,
  input  logic                         in_ready_i,
  input  logic [7:0]                   in_data_i,   // [0] cell_in
  input  logic [0:0]                   in_user_i,   // [0] flush
  input  logic                         out_valid_i,
  input  logic                         out_ready_i,
  input  logic [7:0]                   out_data_i,  // [0] cell_out
  input  logic                         out_last_i,
  output int                           awaiting_o,
  output int                           failures_o
);

  localparam int unsigned COL_W = $clog2(MAX_COLS);

  typedef struct packed {
    logic alive;
    logic is_last;
  } next_gen_t;

  logic [ca_pkg::CFG_W-1:0] rows_reg;
  logic [ca_pkg::CFG_W-1:0] cols_reg;
  logic                     upper_q  [MAX_COLS];
  logic                     middle_q [MAX_COLS];
  logic [8:0]               window;
  int unsigned              col_pos;
  int unsigned              row_pos;
  int unsigned              given;
  int                       failures;
  int                       words_seen;
  next_gen_t                next_gen_q [$];

  initial begin
    awaiting_o = 0;
    failures_o = 0;
  end

  function automatic int unsigned used_dim(input logic [ca_pkg::CFG_W-1:0] v,
                                           input int unsigned hi);
    if (v < ca_pkg::DIM_MIN) return 32'(ca_pkg::DIM_MIN);
    if (32'(v) > hi) return hi;
    return 32'(v);
  endfunction

  function automatic void advance_generation(input logic cell_in, input logic flush);
    int unsigned      rows;
    int unsigned      cols;
    int unsigned      orow;
    int unsigned      ocol;
    int unsigned      live;
    logic [COL_W-1:0] idx;
    logic             fresh;
    logic             up;
    logic             mid;
    logic             centre;
    logic             produce;
    next_gen_t        res;
    rows  = used_dim(rows_reg, MAX_ROWS);
    cols  = used_dim(cols_reg, MAX_COLS);
    fresh = flush ? 1'b0 : cell_in;
    // a column left past a narrowed width wraps to the next row
    if (col_pos >= cols) begin
      col_pos = 0;
      row_pos++;
    end
    idx = COL_W'(col_pos);
    up  = upper_q[idx];
    mid = middle_q[idx];
    upper_q[idx]  = mid;
    middle_q[idx] = fresh;
    window  = {window[5:0], fresh, mid, up};
    produce = (row_pos >= 2) || (row_pos == 1 && col_pos >= 1);
    col_pos++;
    if (col_pos >= cols) begin
      col_pos = 0;
      row_pos++;
    end
    if (!produce) return;
    orow      = given / cols;
    ocol      = given % cols;
    centre    = window[4];
    res.alive = centre;
    if (orow >= 1 && orow + 2 <= rows && ocol >= 1 && ocol + 2 <= cols) begin
      live = unsigned'($countones(window)) - 32'(window[4]);
      if (!centre && (live == ca_pkg::LIVE_LO || live == ca_pkg::LIVE_HI)) res.alive = 1'b1;
      else if (centre && (live < ca_pkg::LIVE_LO || live > ca_pkg::LIVE_HI)) res.alive = 1'b0;
    end
    res.is_last = (given + 1 >= rows * cols);
    next_gen_q.push_back(res);
    if (res.is_last) begin
      given   = 0;
      col_pos = 0;
      row_pos = 0;
    end else begin
      given++;
    end
  endfunction

  task automatic note_mismatch(input string what, input logic expected, input logic actual);
    if (failures < 10) begin
      $display("mismatch in %s at result word %0d: expected %b, got %b",
               what, words_seen, expected, actual);
    end
    failures++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : watch
    next_gen_t res;
    if (!rst_ni) begin
      rows_reg = ca_pkg::CFG_RESET;
      cols_reg = ca_pkg::CFG_RESET;
      upper_q  = '{default: 1'b0};
      middle_q = '{default: 1'b0};
      window  = '0;
      col_pos = 0;
      row_pos = 0;
      given   = 0;
      next_gen_q.delete();
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (next_gen_q.size() == 0) begin
          note_mismatch("unexpected word", 1'bx, out_data_i[0]);
        end else begin
          res = next_gen_q.pop_front();
          if (res.alive !== out_data_i[0]) note_mismatch("cell_out", res.alive, out_data_i[0]);
          if (res.is_last !== out_last_i) note_mismatch("last_cell", res.is_last, out_last_i);
        end
        words_seen++;
      end
      if (cfg_valid_i && cfg_ready_i) begin
        case (ca_pkg::cfg_reg_e'(cfg_index_i))
          ca_pkg::REG_GRID_ROWS: rows_reg = cfg_data_i;
          ca_pkg::REG_GRID_COLS: cols_reg = cfg_data_i;
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_i) advance_generation(in_data_i[0], in_user_i[0]);
    end
    awaiting_o <= next_gen_q.size();
    failures_o <= failures;
  end

endmodule

// ----- tb/testbench.sv -----
// testbench top for cellular_automaton_generation_step: clock, reset, register writes,
// grid stimulus with random idling and output back-pressure, and the final verdict
// depends on ca_pkg, the block and ca_generation_checker
`timescale 1ns / 100ps

module testbench;

  localparam int unsigned MAX_COLS = ca_pkg::MAX_COLS_DEF;
  localparam int unsigned MAX_ROWS = ca_pkg::MAX_ROWS_DEF;

  typedef enum int {PACE_FREE, PACE_HALF, PACE_SLOW, PACE_BUSY} pace_e;

  logic                     clk;
  logic                     rst_n         = 1'b0;
  logic                     cfg_valid     = 1'b0;
  logic                     cfg_ready;
  ca_pkg::cfg_reg_e         cfg_index     = ca_pkg::REG_GRID_ROWS;
  logic [ca_pkg::CFG_W-1:0] cfg_data      = '0;
  logic                     s_axis_tvalid = 1'b0;
  logic                     s_axis_tready;
  logic [7:0]               s_axis_tdata  = '0;
  logic [0:0]               s_axis_tuser  = '0;
  logic                     m_axis_tvalid;
  logic                     m_axis_tready = 1'b0;
  logic [7:0]               m_axis_tdata;
  logic                     m_axis_tlast;
  logic                     hold_off      = 1'b0;
  logic                     squeeze_go    = 1'b0;
  int                       awaiting;
  int                       failures;
  int                       words_sent    = 0;
  int                       burst_left    = 0;

  cellular_automaton_generation_step #(
    .MAX_COLS(MAX_COLS),
    .MAX_ROWS(MAX_ROWS)
  ) uut (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .cfg_valid_i  (cfg_valid),
    .cfg_ready_o  (cfg_ready),
    .cfg_index_i  (cfg_index),
    .cfg_data_i   (cfg_data),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast)
  );

  ca_generation_checker #(
    .MAX_COLS(MAX_COLS),
    .MAX_ROWS(MAX_ROWS)
  ) gen_check (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .cfg_valid_i(cfg_valid),
    .cfg_ready_i(cfg_ready),
    .cfg_index_i(cfg_index),
    .cfg_data_i (cfg_data),
    .in_valid_i (s_axis_tvalid),
    .in_ready_i (s_axis_tready),
    .in_data_i  (s_axis_tdata),
    .in_user_i  (s_axis_tuser),
    .out_valid_i(m_axis_tvalid),
    .out_ready_i(m_axis_tready),
    .out_data_i (m_axis_tdata),
    .out_last_i (m_axis_tlast),
    .awaiting_o (awaiting),
    .failures_o (failures)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #20_000_000;
    $display("Test completed with failures");
    $finish;
  end

  initial begin : drain_side
    pace_e pace;
    int    pace_left;
    pace      = PACE_FREE;
    pace_left = 0;
    forever begin
      @(posedge clk);
      if (pace_left == 0) begin
        pace      = pace_e'($urandom_range(0, 3));
        pace_left = $urandom_range(10, 150);
      end
      pace_left--;
      if (hold_off) begin
        m_axis_tready <= 1'b0;
      end else begin
        case (pace)
          PACE_FREE: m_axis_tready <= 1'b1;
          PACE_HALF: m_axis_tready <= 1'($urandom_range(0, 1));
          PACE_SLOW: m_axis_tready <= ($urandom_range(0, 3) == 0);
          default:   m_axis_tready <= ($urandom_range(0, 7) != 0);
        endcase
      end
    end
  end

  // long output stall while the sender keeps offering words
  initial begin : squeeze
    int held;
    held = 0;
    wait (squeeze_go);
    hold_off <= 1'b1;
    while (held < 400) begin
      @(posedge clk);
      held++;
    end
    hold_off <= 1'b0;
  end

  task automatic send_word(input logic alive, input logic flush);
    int gap;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 12);
      gap        = $urandom_range(0, 5);
      if (gap != 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {7'b0, alive};
    s_axis_tuser  <= flush;
    do @(posedge clk); while (!s_axis_tready);
    words_sent++;
  endtask

  // grid cells, then cols+1 drain words; rough mixes in flushes and late cells
  task automatic send_grid(input int rows, input int cols, input int density, input bit rough);
    logic alive;
    logic flush;
    for (int i = 0; i < rows * cols + cols + 1; i++) begin
      alive = ($urandom_range(0, 99) < density);
      if (i < rows * cols) flush = rough && ($urandom_range(0, 19) == 0);
      else flush = !(rough && ($urandom_range(0, 9) == 0));
      send_word(alive, flush);
    end
  endtask

  task automatic load_dims(input bit set_rows, input logic [ca_pkg::CFG_W-1:0] rows,
                           input bit set_cols, input logic [ca_pkg::CFG_W-1:0] cols);
    s_axis_tvalid <= 1'b0;
    burst_left = 0;
    repeat (2) @(posedge clk);
    wait (awaiting == 0);
    repeat (8) @(posedge clk);
    cfg_valid <= 1'b1;
    if (set_rows) begin
      cfg_index <= ca_pkg::REG_GRID_ROWS;
      cfg_data  <= rows;
      do @(posedge clk); while (!cfg_ready);
    end
    if (set_cols) begin
      cfg_index <= ca_pkg::REG_GRID_COLS;
      cfg_data  <= cols;
      do @(posedge clk); while (!cfg_ready);
    end
    cfg_valid <= 1'b0;
  endtask

  initial begin : stimulus
    logic [14:0]              pattern;
    logic [ca_pkg::CFG_W-1:0] r_val;
    logic [ca_pkg::CFG_W-1:0] c_val;
    int                       r_eff;
    int                       c_eff;
    int                       which;
    int                       density;
    int                       n;
    int                       start_count;
    bit                       first;
    pattern = 15'b11001_01100_10011;
    r_eff   = 3;
    c_eff   = 3;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // 3x5 grid with a flush among the cells and a live cell among the drain words
    load_dims(1'b1, 11'd3, 1'b1, 11'd5);
    for (int i = 0; i < 21; i++) begin
      send_word((i < 15) ? pattern[4'(i)] : (i == 17), (i == 6) || (i >= 15 && i != 17));
    end

    // undersized height and width, both clamped up to three
    load_dims(1'b1, 11'd2, 1'b1, 11'd1);
    send_grid(3, 3, 50, 1'b0);

    start_count = words_sent;
    first       = 1'b1;
    while (words_sent - start_count < 1100) begin
      if (first) begin
        which = 2;
        r_val = 11'd12;
        c_val = 11'd12;
      end else begin
        which = $urandom_range(0, 2);
        r_val = ($urandom_range(0, 9) == 0) ? 11'($urandom_range(0, 2))
                                            : 11'($urandom_range(3, 12));
        c_val = ($urandom_range(0, 9) == 0) ? 11'($urandom_range(0, 2))
                                            : 11'($urandom_range(3, 12));
      end
      load_dims(which != 1, r_val, which != 0, c_val);
      if (which != 1) r_eff = (r_val < 3) ? 3 : int'(r_val);
      if (which != 0) c_eff = (c_val < 3) ? 3 : int'(c_val);
      if (first) begin
        squeeze_go <= 1'b1;
        first = 1'b0;
      end
      n       = $urandom_range(0, 9);
      density = (n == 0) ? 0 : (n == 1) ? 100 : $urandom_range(15, 70);
      if ($urandom_range(0, 9) == 0) begin
        // stray words that break the grid alignment
        repeat ($urandom_range(1, 20)) begin
          send_word(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
        end
      end else begin
        repeat ($urandom_range(1, 2)) send_grid(r_eff, c_eff, density, $urandom_range(0, 2) == 0);
      end
    end

    s_axis_tvalid <= 1'b0;
    repeat (2) @(posedge clk);
    wait (awaiting == 0);
    repeat (20) @(posedge clk);
    if (failures == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
